### rtl/http_request_line_classifier_unit_defines.svh
// assertion macros for the request line classifier checker
`ifndef HTTP_REQUEST_LINE_CLASSIFIER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_LINE_CLASSIFIER_UNIT_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define HRLC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define HRLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/hrlc_pkg.sv
// shared types, constants and lookup functions for the request line classifier
package hrlc_pkg;

  localparam int unsigned MIN_LINE_BYTES = 8;

  typedef enum logic [2:0] {
    CLASS_BAD                = 3'd0,
    CLASS_ROOT               = 3'd1,
    CLASS_HEALTH             = 3'd2,
    CLASS_NOT_FOUND          = 3'd3,
    CLASS_METHOD_NOT_ALLOWED = 3'd4,
    CLASS_TOO_LARGE          = 3'd5
  } request_class_t;

  typedef enum logic {
    REG_REQUEST_LIMIT = 1'b0,
    REG_LINE_LIMIT    = 1'b1
  } reg_index_t;

  localparam logic [15:0] REQUEST_LIMIT_RESET = 16'd512;
  localparam logic [7:0]  LINE_LIMIT_RESET    = 8'd128;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  localparam logic [7:0]  MIN_LINE   = 8'(MIN_LINE_BYTES);
  localparam logic [7:0]  GET_LEN    = 8'd3;
  localparam logic [7:0]  ROOT_LEN   = 8'd1;
  localparam logic [7:0]  HEALTH_LEN = 8'd7;
  localparam logic [7:0]  COUNT_MAX  = 8'hff;
  localparam logic [15:0] POS_MAX    = 16'hffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } beat_t;

  typedef struct packed {
    logic [15:0] byte_position;
    logic        line_ended;
    logic [7:0]  line_length;
    logic        method_space_seen;
    logic [7:0]  method_length;
    logic        get_prefix_match;
    logic        path_slash_ok;
    logic        path_end_seen;
    logic [7:0]  path_length;
    logic        health_match;
  } scan_t;

  localparam scan_t SCAN_RESET = '{
    byte_position:     16'd0,
    line_ended:        1'b0,
    line_length:       8'd0,
    method_space_seen: 1'b0,
    method_length:     8'd0,
    get_prefix_match:  1'b1,
    path_slash_ok:     1'b0,
    path_end_seen:     1'b0,
    path_length:       8'd0,
    health_match:      1'b1
  };

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] health_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2f;
      3'd1:    c = 8'h68;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h6c;
      3'd5:    c = 8'h74;
      default: c = 8'h68;
    endcase
    return c;
  endfunction

endpackage

### rtl/hrlc_in_if.sv
// byte channel into the classifier
interface hrlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

### rtl/hrlc_out_if.sv
// class code channel out of the classifier
interface hrlc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] request_class;

  modport source (output valid, output request_class, input ready);
  modport sink (input valid, input request_class, output ready);
endinterface

### rtl/http_request_line_classifier_unit.sv
// top level of the http request line classifier
//
// request: one beat per byte of a received buffer, final_byte set on the last
// byte. verdict: one beat per buffer carrying request_class (0 bad, 1 root,
// 2 health, 3 not found, 4 method not allowed, 5 too large).
// config: cfg_write with cfg_index 0 sets the request limit (16 bit, reset 512),
// cfg_index 1 sets the line limit (low 8 bits of cfg_data, reset 128). write
// only while no buffer is in flight.
// throughput: one byte per cycle, except that a final byte waits in the input
// register while the verdict beat is stalled. the final byte's class is loaded
// into the result register, whose valid flag drives verdict.valid.
// reset returns the limits to 512 and 128 and clears the scan state and all
// valid flags.
// when verdict is stalled, the result register holds its beat; non-final bytes
// keep flowing through the scan, the next final byte parks in the input
// register and request.ready stays low until the verdict beat is taken.
module http_request_line_classifier_unit (
  input  logic       clk,
  input  logic       rst,
  hrlc_in_if.sink    request,
  hrlc_out_if.source verdict,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] request_limit;
  logic [7:0]  line_limit;

  hrlc_pkg::beat_t          in_beat;
  hrlc_pkg::beat_t          held_beat;
  logic                     held_valid;
  logic                     advance;
  hrlc_pkg::scan_t          scan_next;
  hrlc_pkg::request_class_t class_next;
  logic                     out_valid;
  hrlc_pkg::request_class_t out_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_limit <= hrlc_pkg::REQUEST_LIMIT_RESET;
      line_limit    <= hrlc_pkg::LINE_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (hrlc_pkg::reg_index_t'(cfg_index))
        hrlc_pkg::REG_REQUEST_LIMIT: request_limit <= cfg_data;
        hrlc_pkg::REG_LINE_LIMIT:    line_limit    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_beat.data_byte  = request.data_byte;
  assign in_beat.final_byte = request.final_byte;

  assign advance = held_valid && (!held_beat.final_byte || !out_valid || verdict.ready);

  hrlc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_beat    (in_beat),
    .in_ready   (request.ready),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  hrlc_track u_track (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .beat       (held_beat),
    .line_limit (line_limit),
    .scan_next  (scan_next)
  );

  hrlc_class u_class (
    .scan          (scan_next),
    .request_limit (request_limit),
    .line_limit    (line_limit),
    .request_class (class_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && held_beat.final_byte) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_beat.final_byte) begin
      out_class <= class_next;
    end
  end

  assign verdict.valid         = out_valid;
  assign verdict.request_class = out_class;

endmodule

### rtl/hrlc_in_stage.sv
// input register for byte beats
module hrlc_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hrlc_pkg::beat_t in_beat,
  output logic           in_ready,
  input  logic           advance,
  output logic           held_valid,
  output hrlc_pkg::beat_t held_beat
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_beat <= in_beat;
    end
  end

endmodule

### rtl/hrlc_track.sv
// per-buffer scan state: counters and match flags updated once per byte
module hrlc_track (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  hrlc_pkg::beat_t beat,
  input  logic [7:0]      line_limit,
  output hrlc_pkg::scan_t scan_next
);

  hrlc_pkg::scan_t scan;

  always_comb begin
    logic [7:0] b;
    logic       in_line;
    b = beat.data_byte;
    in_line = !scan.line_ended && (scan.line_length < line_limit);
    scan_next = scan;
    if (scan.byte_position != hrlc_pkg::POS_MAX) begin
      scan_next.byte_position = scan.byte_position + 16'd1;
    end
    if (in_line) begin
      if (b == hrlc_pkg::CHAR_CR || b == hrlc_pkg::CHAR_LF) begin
        scan_next.line_ended = 1'b1;
      end else begin
        scan_next.line_length = scan.line_length + 8'd1;
        if (!scan.method_space_seen) begin
          if (b == hrlc_pkg::CHAR_SPACE) begin
            scan_next.method_space_seen = 1'b1;
          end else begin
            if (scan.method_length < hrlc_pkg::GET_LEN &&
                b != hrlc_pkg::get_char(scan.method_length[1:0])) begin
              scan_next.get_prefix_match = 1'b0;
            end
            if (scan.method_length != hrlc_pkg::COUNT_MAX) begin
              scan_next.method_length = scan.method_length + 8'd1;
            end
          end
        end else if (!scan.path_end_seen) begin
          if (scan.path_length == 8'd0) begin
            scan_next.path_slash_ok = (b == hrlc_pkg::CHAR_SLASH);
          end
          if (b == hrlc_pkg::CHAR_SPACE) begin
            scan_next.path_end_seen = 1'b1;
          end else begin
            if (scan.path_length < hrlc_pkg::HEALTH_LEN &&
                b != hrlc_pkg::health_char(scan.path_length[2:0])) begin
              scan_next.health_match = 1'b0;
            end
            if (scan.path_length != hrlc_pkg::COUNT_MAX) begin
              scan_next.path_length = scan.path_length + 8'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= hrlc_pkg::SCAN_RESET;
    end else if (advance) begin
      scan <= beat.final_byte ? hrlc_pkg::SCAN_RESET : scan_next;
    end
  end

endmodule

### rtl/hrlc_class.sv
// class decision from the scan state after the final byte
module hrlc_class (
  input  hrlc_pkg::scan_t        scan,
  input  logic [15:0]            request_limit,
  input  logic [7:0]             line_limit,
  output hrlc_pkg::request_class_t request_class
);

  always_comb begin
    if (scan.byte_position >= request_limit) begin
      request_class = hrlc_pkg::CLASS_TOO_LARGE;
    end else if (scan.line_length < hrlc_pkg::MIN_LINE || scan.line_length >= line_limit) begin
      request_class = hrlc_pkg::CLASS_BAD;
    end else if (!scan.method_space_seen || scan.method_length == 8'd0) begin
      request_class = hrlc_pkg::CLASS_BAD;
    end else if (scan.method_length != hrlc_pkg::GET_LEN || !scan.get_prefix_match) begin
      request_class = hrlc_pkg::CLASS_METHOD_NOT_ALLOWED;
    end else if (!scan.path_slash_ok || !scan.path_end_seen) begin
      request_class = hrlc_pkg::CLASS_BAD;
    end else if (scan.path_length == hrlc_pkg::ROOT_LEN) begin
      request_class = hrlc_pkg::CLASS_ROOT;
    end else if (scan.path_length == hrlc_pkg::HEALTH_LEN && scan.health_match) begin
      request_class = hrlc_pkg::CLASS_HEALTH;
    end else begin
      request_class = hrlc_pkg::CLASS_NOT_FOUND;
    end
  end

endmodule

### rtl/hrlc_checker.sv
// port-level checks for the request line classifier, bound to the top level
`include "http_request_line_classifier_unit_defines.svh"

module hrlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_final,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_class
);

  `HRLC_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_class), "verdict beat changed while stalled")

  `HRLC_ASSERT_SAME(a_class_range, clk, rst, out_valid, out_class <= hrlc_pkg::CLASS_TOO_LARGE, "class code out of range")

  `HRLC_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !out_valid, "verdict valid right after reset")

  `HRLC_ASSERT_SAME(a_result_cause, clk, rst, $rose(out_valid), $past(in_valid && in_ready && in_final, 2), "verdict without a final byte two cycles earlier")

endmodule

bind http_request_line_classifier_unit hrlc_checker u_hrlc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (request.valid),
  .in_ready  (request.ready),
  .in_final  (request.final_byte),
  .out_valid (verdict.valid),
  .out_ready (verdict.ready),
  .out_class (verdict.request_class)
);

### tb/sv/http_request_line_classifier_unit_tb.sv
// testbench for the http request line classifier: random buffers, scoreboard of class codes
`timescale 1ns / 1ps

module http_request_line_classifier_unit_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int BYTE_TARGET = 1050;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic cfg_index;
  logic [15:0] cfg_data;

  hrlc_in_if request_ch ();
  hrlc_out_if verdict_ch ();

  http_request_line_classifier_unit dut (
    .clk(clk),
    .rst(rst),
    .request(request_ch),
    .verdict(verdict_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  hrlc_pkg::beat_t byte_backlog[$];
  hrlc_pkg::request_class_t expected_classes[$];
  logic [7:0] msg_bytes[$];

  logic [15:0] request_limit_m = hrlc_pkg::REQUEST_LIMIT_RESET;
  logic [7:0] line_limit_m = hrlc_pkg::LINE_LIMIT_RESET;
  hrlc_pkg::scan_t scan = hrlc_pkg::SCAN_RESET;

  string method_text = "GET";
  string health_text = "/health";

  int send_idle_pct = 7;
  int recv_idle_pct = 47;
  int hold_tickets = 0;
  int holds_done = 0;
  int hold_left = 0;
  int error_count = 0;
  int sent_bytes = 0;
  int stall_cycles = 0;

  function automatic hrlc_pkg::request_class_t decide_class();
    if (scan.byte_position >= request_limit_m) return hrlc_pkg::CLASS_TOO_LARGE;
    if (scan.line_length < hrlc_pkg::MIN_LINE || scan.line_length >= line_limit_m)
      return hrlc_pkg::CLASS_BAD;
    if (!scan.method_space_seen || scan.method_length == 8'd0) return hrlc_pkg::CLASS_BAD;
    if (scan.method_length != hrlc_pkg::GET_LEN || !scan.get_prefix_match)
      return hrlc_pkg::CLASS_METHOD_NOT_ALLOWED;
    if (!scan.path_slash_ok || !scan.path_end_seen) return hrlc_pkg::CLASS_BAD;
    if (scan.path_length == hrlc_pkg::ROOT_LEN) return hrlc_pkg::CLASS_ROOT;
    if (scan.path_length == hrlc_pkg::HEALTH_LEN && scan.health_match)
      return hrlc_pkg::CLASS_HEALTH;
    return hrlc_pkg::CLASS_NOT_FOUND;
  endfunction

  function automatic void track_byte(logic [7:0] b, logic fin);
    if (scan.byte_position != hrlc_pkg::POS_MAX) scan.byte_position++;
    if (!scan.line_ended && scan.line_length < line_limit_m) begin
      if (b == hrlc_pkg::CHAR_CR || b == hrlc_pkg::CHAR_LF) begin
        scan.line_ended = 1'b1;
      end else begin
        if (!scan.method_space_seen) begin
          if (b == hrlc_pkg::CHAR_SPACE) begin
            scan.method_space_seen = 1'b1;
          end else begin
            if (scan.method_length < hrlc_pkg::GET_LEN &&
                b != 8'(method_text[scan.method_length]))
              scan.get_prefix_match = 1'b0;
            if (scan.method_length != hrlc_pkg::COUNT_MAX) scan.method_length++;
          end
        end else if (!scan.path_end_seen) begin
          if (scan.path_length == 8'd0) scan.path_slash_ok = (b == hrlc_pkg::CHAR_SLASH);
          if (b == hrlc_pkg::CHAR_SPACE) begin
            scan.path_end_seen = 1'b1;
          end else begin
            if (scan.path_length < hrlc_pkg::HEALTH_LEN &&
                b != 8'(health_text[scan.path_length]))
              scan.health_match = 1'b0;
            if (scan.path_length != hrlc_pkg::COUNT_MAX) scan.path_length++;
          end
        end
        scan.line_length++;
      end
    end
    if (fin) begin
      expected_classes.push_back(decide_class());
      scan = hrlc_pkg::SCAN_RESET;
    end
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(8'(s[i]));
  endfunction

  function automatic void queue_buffer();
    hrlc_pkg::beat_t b;
    foreach (msg_bytes[i]) begin
      b.data_byte = msg_bytes[i];
      b.final_byte = (i == msg_bytes.size() - 1);
      byte_backlog.push_back(b);
    end
    sent_bytes += msg_bytes.size();
    msg_bytes.delete();
  endfunction

  function automatic void make_sized(int total);
    add_text("GET / HTTP/1.1\r\n");
    while (msg_bytes.size() < total) msg_bytes.push_back(8'($urandom_range(32, 126)));
    queue_buffer();
  endfunction

  function automatic void make_long_line(int span);
    add_text("GET /");
    repeat (span - 6) msg_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
    add_text(" \r\n");
    queue_buffer();
  endfunction

  function automatic void make_random_request();
    int kind;
    int pick;
    int len;
    int cut;
    kind = $urandom_range(99);
    if (kind < 12) begin
      len = $urandom_range(1, 40);
      repeat (len) msg_bytes.push_back(8'($urandom_range(255)));
    end else begin
      pick = $urandom_range(11);
      case (pick)
        0, 1, 2, 3, 4, 5: add_text("GET");
        6: add_text("POST");
        7: add_text("GE");
        8: add_text("GETS");
        9: add_text("gET");
        10: ;
        default: repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(65, 90)));
      endcase
      pick = $urandom_range(99);
      if (pick < 85) add_text(" ");
      else if (pick < 92) add_text("  ");
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2: add_text("/");
        3, 4: add_text("/health");
        5: add_text("/healthz");
        6: add_text("/heal");
        7: add_text("/index.html");
        8: add_text("health");
        default: begin
          add_text("/");
          len = ($urandom_range(14) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 12);
          repeat (len) msg_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
        end
      endcase
      pick = $urandom_range(9);
      case (pick)
        7: add_text(" ");
        8: ;
        9: add_text(" X");
        default: add_text(" HTTP/1.1");
      endcase
      pick = $urandom_range(3);
      case (pick)
        0: add_text("\r\n");
        1: add_text("\n");
        2: add_text("\r");
        default: ;
      endcase
      len = $urandom_range(0, 30);
      repeat (len) begin
        if ($urandom_range(1) == 1) msg_bytes.push_back(8'($urandom_range(32, 126)));
        else msg_bytes.push_back(8'($urandom_range(255)));
      end
      if (kind < 22) begin
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
    queue_buffer();
  endfunction

  function automatic void add_random(int count);
    repeat (count) make_random_request();
  endfunction

  task automatic wait_idle();
    while (byte_backlog.size() != 0 || request_ch.valid || expected_classes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limits(logic [15:0] request_limit, logic [15:0] line_data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= hrlc_pkg::REG_REQUEST_LIMIT;
    cfg_data <= request_limit;
    request_limit_m = request_limit;
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= hrlc_pkg::REG_LINE_LIMIT;
    cfg_data <= line_data;
    line_limit_m = line_data[7:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic start_phase(int send_pct, int recv_pct, logic [15:0] request_limit,
                             logic [15:0] line_data);
    wait_idle();
    write_limits(request_limit, line_data);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // request side
  always @(posedge clk) begin
    hrlc_pkg::beat_t next_beat;
    if (rst) begin
      request_ch.valid <= 1'b0;
    end else begin
      if (request_ch.valid && request_ch.ready)
        track_byte(request_ch.data_byte, request_ch.final_byte);
      if (!request_ch.valid || request_ch.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = byte_backlog.pop_front();
          request_ch.valid <= 1'b1;
          request_ch.data_byte <= next_beat.data_byte;
          request_ch.final_byte <= next_beat.final_byte;
        end else begin
          request_ch.valid <= 1'b0;
        end
      end
    end
  end

  // verdict side
  always @(posedge clk) begin
    hrlc_pkg::request_class_t want;
    if (rst) begin
      verdict_ch.ready <= 1'b0;
    end else begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (expected_classes.size() == 0) begin
          $error("request_class: expected none, got %0d", verdict_ch.request_class);
          error_count++;
        end else begin
          want = expected_classes.pop_front();
          if (verdict_ch.request_class !== want) begin
            $error("request_class: expected %0d, got %0d", want, verdict_ch.request_class);
            error_count++;
          end
        end
      end
      if (hold_tickets != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) ||
        (verdict_ch.valid && verdict_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    request_ch.valid = 1'b0;
    request_ch.data_byte = 8'd0;
    request_ch.final_byte = 1'b0;
    verdict_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = hrlc_pkg::REG_REQUEST_LIMIT;
    cfg_data = 16'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limits
    add_text("GET / HTTP/1.1\r\n");
    queue_buffer();
    add_text("GET /health HTTP/1.1\r\n");
    queue_buffer();
    add_text("GET /healthz HTTP/1.1\n");
    queue_buffer();
    add_text("POST / HTTP/1.1\r\n");
    queue_buffer();
    add_text("GET /\r\n");
    queue_buffer();
    add_text(" GET / HTTP/1.1\r\n");
    queue_buffer();
    add_text("GETX/ab\r");
    queue_buffer();
    add_text("GET index HTTP/1.1\r\n");
    queue_buffer();
    add_text("GET /health\r\n");
    queue_buffer();
    msg_bytes.push_back(8'hff);
    queue_buffer();
    msg_bytes.push_back(8'h00);
    queue_buffer();
    add_random(2);

    start_phase(7, 47, 16'd60, 16'd40);
    add_random(1);
    make_sized(59);
    make_sized(60);
    make_long_line(39);
    make_long_line(40);

    start_phase(7, 47, 16'hffff, 16'd255);
    add_random(1);
    make_long_line(254);
    make_long_line(255);

    start_phase(47, 7, 16'd1, 16'd200);
    msg_bytes.push_back(8'h47);
    queue_buffer();
    add_random(1);

    start_phase(47, 7, 16'd0, 16'h5a80);
    add_random(1);

    start_phase(47, 7, 16'd300, 16'hff09);
    add_text("GET /  X");
    queue_buffer();
    add_text("GET /  XY");
    queue_buffer();

    start_phase(47, 7, 16'd200, 16'd8);
    add_text("GET /  X");
    queue_buffer();

    start_phase(47, 7, 16'd400, 16'h0100);
    add_random(1);

    // receiver holds off while the backlog keeps offering beats
    start_phase(0, 0, 16'd512, 16'd20);
    add_random(2);
    make_long_line(19);
    make_long_line(20);
    hold_tickets++;

    start_phase(0, 0, 16'd128, 16'd64);
    add_random(1);
    while (sent_bytes < BYTE_TARGET) make_random_request();

    wait_idle();
    if (expected_classes.size() != 0) begin
      $error("request_class: %0d expected beats never arrived", expected_classes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/hrlc_pkg.sv
rtl/hrlc_in_if.sv
rtl/hrlc_out_if.sv
rtl/hrlc_in_stage.sv
rtl/hrlc_track.sv
rtl/hrlc_class.sv
rtl/http_request_line_classifier_unit.sv
rtl/hrlc_checker.sv
tb/sv/http_request_line_classifier_unit_tb.sv
